FILE: rtl/sbt_pkg.sv
// Shared types and constants for the spectral bin thresher.
// Used by the channel interfaces, the bin store and the top level.
`default_nettype none

package sbt_pkg;

   // Field widths
   localparam int SBT_BIN_W   = 10;
   localparam int SBT_AMP_W   = 32;
   localparam int SBT_FREQ_W  = 32;
   localparam int SBT_CNT_W   = 16;
   localparam int SBT_THR_W   = 32;
   localparam int SBT_DAMP_W  = 16;
   localparam int SBT_SCALE_W = 16;
   localparam int SBT_CSR_DATA_W = 16;

   // Default transform size; bins per frame follow from it
   localparam int SBT_FFT_SIZE_DEF = 1024;
   localparam int SBT_NBINS_DEF    = SBT_FFT_SIZE_DEF / 2 + 1;

   // Register reset values
   localparam logic [SBT_CNT_W-1:0]   SBT_HOLD_FRAMES_RST = 16'd10336;
   localparam logic [SBT_SCALE_W-1:0] SBT_SCALE_RST       = 16'd4096;

   // Per-bin coefficient reset values: 0.1 in Q16.16, 0.99 in Q1.15
   localparam logic [SBT_THR_W-1:0]  SBT_THR_RST  = 32'd6554;
   localparam logic [SBT_DAMP_W-1:0] SBT_DAMP_RST = 16'd32440;

   // Near-one window of a Q4.12 scale, 0.999 .. 1.001
   localparam logic [SBT_SCALE_W-1:0] SBT_WIN_LO = 16'd4092;
   localparam logic [SBT_SCALE_W-1:0] SBT_WIN_HI = 16'd4100;

   // Fraction bits of a Q4.12 scale, and the damping product shift
   // (Q1.15 * Q4.12 = 27 fraction bits on top of Q16.16)
   localparam int SBT_SCALE_FRAC = 12;
   localparam int SBT_DAMP_SHIFT = 27;

   typedef enum logic {
      SBT_ACT_PROCESS = 1'b0,
      SBT_ACT_WRITE   = 1'b1
   } sbt_action_type;

   typedef enum logic [1:0] {
      SBT_REG_HOLD_FRAMES  = 2'd0,
      SBT_REG_HOLD_FOREVER = 2'd1,
      SBT_REG_THR_SCALE    = 2'd2,
      SBT_REG_DAMP_SCALE   = 2'd3
   } sbt_reg_type;

   // Per-bin running state
   typedef struct packed {
      logic [SBT_AMP_W-1:0]  amp;
      logic [SBT_FREQ_W-1:0] freq;
      logic [SBT_CNT_W-1:0]  cnt;
   } sbt_state_type;

   // Per-bin coefficients
   typedef struct packed {
      logic [SBT_THR_W-1:0]  thr;
      logic [SBT_DAMP_W-1:0] damp;
   } sbt_coef_type;

endpackage

`default_nettype wire

FILE: rtl/sbt_if.sv
// Valid/ready channel interfaces: bin requests, results, register writes.
// Depends on sbt_pkg for field widths.
`default_nettype none

interface sbt_req_if import sbt_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [SBT_BIN_W-1:0]         bin_index;
   logic [SBT_AMP_W-1:0]         amplitude;
   logic signed [SBT_FREQ_W-1:0] frequency;
   logic [SBT_THR_W-1:0]         new_threshold;
   logic [SBT_DAMP_W-1:0]        new_damping;

   modport source (output valid, action, bin_index, amplitude, frequency,
                   new_threshold, new_damping, input ready);
   modport sink   (input valid, action, bin_index, amplitude, frequency,
                   new_threshold, new_damping, output ready);
endinterface

interface sbt_rsp_if import sbt_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [SBT_BIN_W-1:0]         out_bin;
   logic [SBT_AMP_W-1:0]         out_amplitude;
   logic signed [SBT_FREQ_W-1:0] out_frequency;
   logic                         refreshed;

   modport source (output valid, out_bin, out_amplitude, out_frequency, refreshed,
                   input ready);
   modport sink   (input valid, out_bin, out_amplitude, out_frequency, refreshed,
                   output ready);
endinterface

interface sbt_csr_if import sbt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                index;
   logic [SBT_CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sbt_bin_store.sv
// Per-bin state and coefficient memories with a post-reset clearing pass.
// Depends on sbt_pkg for the state and coefficient structs.
`default_nettype none

module sbt_bin_store import sbt_pkg::*; #(
   parameter int NBINS = SBT_NBINS_DEF,
   localparam int ADDR_W = $clog2(NBINS)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output sbt_state_type            state_rd,
   output sbt_coef_type             coef_rd,
   input  wire logic                state_we,
   input  wire logic [ADDR_W-1:0]   state_waddr,
   input  wire sbt_state_type       state_wdata,
   input  wire logic                coef_we,
   input  wire logic [ADDR_W-1:0]   coef_waddr,
   input  wire sbt_coef_type        coef_wdata,
   output logic                     clearing
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NBINS - 1);

   sbt_state_type state_mem [NBINS];
   sbt_coef_type  coef_mem  [NBINS];

   sbt_state_type state_rd_ff;
   sbt_coef_type  coef_rd_ff;

   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;

   logic              st_wen;
   logic [ADDR_W-1:0] st_waddr;
   sbt_state_type     st_wdata;
   logic              cf_wen;
   logic [ADDR_W-1:0] cf_waddr;
   sbt_coef_type      cf_wdata;

   assign clr_addr_in = clr_addr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_in;
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // clear pass owns the write ports until it is done
   always_comb begin
      st_wen   = clearing_ff || state_we;
      st_waddr = clearing_ff ? clr_addr_ff : state_waddr;
      st_wdata = clearing_ff ? '0 : state_wdata;
      cf_wen   = clearing_ff || coef_we;
      cf_waddr = clearing_ff ? clr_addr_ff : coef_waddr;
      cf_wdata = clearing_ff ? sbt_coef_type'{thr: SBT_THR_RST, damp: SBT_DAMP_RST}
                             : coef_wdata;
   end

   always_ff @(posedge clock) begin
      if (st_wen) begin
         state_mem[st_waddr] <= st_wdata;
      end
      if (rd_en) begin
         state_rd_ff <= state_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cf_wen) begin
         coef_mem[cf_waddr] <= cf_wdata;
      end
      if (rd_en) begin
         coef_rd_ff <= coef_mem[rd_addr];
      end
   end

   assign state_rd = state_rd_ff;
   assign coef_rd  = coef_rd_ff;
   assign clearing = clearing_ff;

endmodule

`default_nettype wire

FILE: rtl/spectral_bin_thresher_top.sv
// Spectral bin thresher: per-bin hold with threshold, damping and countdown.
// Uses sbt_pkg, the sbt_*_if channel interfaces and sbt_bin_store.
//
// One request per clock unless the block stalls: a process request carries one
// spectral bin (amplitude, frequency) and gives one result in the output register;
// a write request sets the threshold and damping of one bin below FFT_SIZE/2 (a
// write to a higher bin is dropped) and gives no result, as does a process request
// for a bin above FFT_SIZE/2. The pipeline is a memory read at accept, then three
// register stages (threshold product and amplitude difference, 32x32 damping
// product, decision and write-back) and the output register; a result waiting in
// the output register stalls every stage and the input until it is taken.
// A process request for a bin that is still in one of the three stages waits
// until that bin is written back, so back-to-back requests for the same bin
// cannot overlap; ascending bin streams run at one per cycle while nothing stalls.
// After reset the bin memories are swept to their reset values, one bin per
// cycle, over all FFT_SIZE/2+1 bins (513 at the default size), during which no
// request is taken; register writes are taken at any time and should be made
// only while the block is idle.
`default_nettype none

module spectral_bin_thresher_top import sbt_pkg::*; #(
   parameter int FFT_SIZE = SBT_FFT_SIZE_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   sbt_req_if.sink   req,
   sbt_rsp_if.source rsp,
   sbt_csr_if.sink   csr
);

   localparam int NBINS  = FFT_SIZE / 2 + 1;
   localparam int ADDR_W = $clog2(NBINS);
   localparam int EXT_W  = (ADDR_W > SBT_BIN_W) ? ADDR_W : SBT_BIN_W;
   localparam logic [EXT_W-1:0] TOP_BIN = EXT_W'(NBINS - 1);

   localparam int TPROD_W = SBT_THR_W + SBT_SCALE_W;   // Q20.28
   localparam int FAC_W   = SBT_DAMP_W + SBT_SCALE_W;  // damping * scale
   localparam int DPROD_W = SBT_AMP_W + FAC_W;
   localparam int DSH_W   = DPROD_W - SBT_DAMP_SHIFT;

   // ---------------- configuration registers ----------------
   logic [SBT_CNT_W-1:0]   hold_frames_ff;
   logic                   hold_forever_ff;
   logic [SBT_SCALE_W-1:0] thr_scale_ff;
   logic [SBT_SCALE_W-1:0] damp_scale_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_frames_ff  <= SBT_HOLD_FRAMES_RST;
         hold_forever_ff <= 1'b0;
         thr_scale_ff    <= SBT_SCALE_RST;
         damp_scale_ff   <= SBT_SCALE_RST;
      end else if (csr.valid) begin
         unique case (sbt_reg_type'(csr.index))
            SBT_REG_HOLD_FRAMES:  hold_frames_ff  <= csr.data;
            SBT_REG_HOLD_FOREVER: hold_forever_ff <= csr.data[0];
            SBT_REG_THR_SCALE:    thr_scale_ff    <= csr.data;
            SBT_REG_DAMP_SCALE:   damp_scale_ff   <= csr.data;
            default: ;
         endcase
      end
   end

   // plain threshold compare only when both scales sit in their near-one window
   logic use_scale;
   assign use_scale = !(thr_scale_ff >= SBT_WIN_LO && thr_scale_ff <= SBT_WIN_HI) ||
                      !(damp_scale_ff >= SBT_WIN_LO && damp_scale_ff <= SBT_WIN_HI);

   // ---------------- pipeline control ----------------
   logic rsp_valid_ff;
   logic adv;            // whole pipeline moves together
   logic clearing;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff, s2_addr_ff, s3_addr_ff;

   logic [EXT_W-1:0]  bin_ext;
   logic [ADDR_W-1:0] req_addr;
   logic              req_write;
   logic              proc_ok;
   logic              wr_ok;
   logic              hazard;
   logic              accept;
   logic              take;
   logic              copy_all_ff;

   assign adv       = !rsp_valid_ff || rsp.ready;
   assign bin_ext   = EXT_W'(req.bin_index);
   assign req_addr  = bin_ext[ADDR_W-1:0];
   assign req_write = (req.action == SBT_ACT_WRITE);
   assign proc_ok   = !req_write && (bin_ext <= TOP_BIN);
   assign wr_ok     = req_write && (bin_ext < TOP_BIN);

   // a bin still in flight has not been written back yet
   assign hazard = proc_ok && ((s1_valid_ff && s1_addr_ff == req_addr) ||
                               (s2_valid_ff && s2_addr_ff == req_addr) ||
                               (s3_valid_ff && s3_addr_ff == req_addr));

   assign req.ready = adv && !clearing && !hazard;
   assign accept    = req.valid && req.ready;
   assign take      = accept && proc_ok;

   // first frame ends once the top bin has been taken
   always_ff @(posedge clock) begin
      if (reset) begin
         copy_all_ff <= 1'b1;
      end else if (take && bin_ext == TOP_BIN) begin
         copy_all_ff <= 1'b0;
      end
   end

   // ---------------- bin memories ----------------
   sbt_state_type     state_rd;
   sbt_coef_type      coef_rd;
   logic              state_we;
   sbt_state_type     state_wdata;
   logic [ADDR_W-1:0] rd_addr;

   assign rd_addr = proc_ok ? req_addr : '0;

   sbt_bin_store #(
      .NBINS (NBINS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (adv),
      .rd_addr     (rd_addr),
      .state_rd    (state_rd),
      .coef_rd     (coef_rd),
      .state_we    (state_we),
      .state_waddr (s3_addr_ff),
      .state_wdata (state_wdata),
      .coef_we     (accept && wr_ok),
      .coef_waddr  (req_addr),
      .coef_wdata  (sbt_coef_type'{thr: req.new_threshold, damp: req.new_damping}),
      .clearing    (clearing)
   );

   // ---------------- stage 1: request registered, memory data present ----------
   logic [SBT_BIN_W-1:0]  s1_bin_ff;
   logic [SBT_AMP_W-1:0]  s1_amp_ff;
   logic [SBT_FREQ_W-1:0] s1_freq_ff;
   logic                  s1_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_addr_ff  <= req_addr;
         s1_bin_ff   <= req.bin_index;
         s1_amp_ff   <= req.amplitude;
         s1_freq_ff  <= req.frequency;
         s1_first_ff <= copy_all_ff;
      end
   end

   // |held - input| and the two narrow products
   logic [SBT_AMP_W-1:0] diff_in;
   logic [TPROD_W-1:0]   tprod_in;
   logic [FAC_W-1:0]     fac_in;

   always_comb begin
      diff_in  = (state_rd.amp > s1_amp_ff) ? state_rd.amp - s1_amp_ff
                                            : s1_amp_ff - state_rd.amp;
      tprod_in = TPROD_W'(coef_rd.thr) * TPROD_W'(thr_scale_ff);
      fac_in   = FAC_W'(coef_rd.damp) * FAC_W'(damp_scale_ff);
   end

   // ---------------- stage 2 ----------------
   logic [SBT_BIN_W-1:0]  s2_bin_ff;
   logic [SBT_AMP_W-1:0]  s2_amp_ff;
   logic [SBT_FREQ_W-1:0] s2_freq_ff;
   logic                  s2_first_ff;
   logic [SBT_AMP_W-1:0]  s2_held_ff;
   logic [SBT_FREQ_W-1:0] s2_hfreq_ff;
   logic [SBT_CNT_W-1:0]  s2_cnt_ff;
   logic [SBT_THR_W-1:0]  s2_thr_ff;
   logic [SBT_AMP_W-1:0]  s2_diff_ff;
   logic [TPROD_W-1:0]    s2_tprod_ff;
   logic [FAC_W-1:0]      s2_fac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_addr_ff  <= s1_addr_ff;
         s2_bin_ff   <= s1_bin_ff;
         s2_amp_ff   <= s1_amp_ff;
         s2_freq_ff  <= s1_freq_ff;
         s2_first_ff <= s1_first_ff;
         s2_held_ff  <= state_rd.amp;
         s2_hfreq_ff <= state_rd.freq;
         s2_cnt_ff   <= state_rd.cnt;
         s2_thr_ff   <= coef_rd.thr;
         s2_diff_ff  <= diff_in;
         s2_tprod_ff <= tprod_in;
         s2_fac_ff   <= fac_in;
      end
   end

   // damped amplitude product, full width
   logic [DPROD_W-1:0] dprod_in;
   assign dprod_in = DPROD_W'(s2_held_ff) * DPROD_W'(s2_fac_ff);

   // ---------------- stage 3: decision and write-back ----------------
   logic [SBT_BIN_W-1:0]  s3_bin_ff;
   logic [SBT_AMP_W-1:0]  s3_amp_ff;
   logic [SBT_FREQ_W-1:0] s3_freq_ff;
   logic                  s3_first_ff;
   logic [SBT_FREQ_W-1:0] s3_hfreq_ff;
   logic [SBT_CNT_W-1:0]  s3_cnt_ff;
   logic [SBT_THR_W-1:0]  s3_thr_ff;
   logic [SBT_AMP_W-1:0]  s3_diff_ff;
   logic [TPROD_W-1:0]    s3_tprod_ff;
   logic [DPROD_W-1:0]    s3_dprod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_addr_ff  <= s2_addr_ff;
         s3_bin_ff   <= s2_bin_ff;
         s3_amp_ff   <= s2_amp_ff;
         s3_freq_ff  <= s2_freq_ff;
         s3_first_ff <= s2_first_ff;
         s3_hfreq_ff <= s2_hfreq_ff;
         s3_cnt_ff   <= s2_cnt_ff;
         s3_thr_ff   <= s2_thr_ff;
         s3_diff_ff  <= s2_diff_ff;
         s3_tprod_ff <= s2_tprod_ff;
         s3_dprod_ff <= dprod_in;
      end
   end

   logic [TPROD_W-1:0]   diff_q;     // difference lined up with Q20.28
   logic                 moved;
   logic                 refresh;
   logic [DSH_W-1:0]     dshift;
   logic [SBT_AMP_W-1:0] damped;

   always_comb begin
      diff_q  = TPROD_W'({s3_diff_ff, {SBT_SCALE_FRAC{1'b0}}});
      moved   = use_scale ? (diff_q > s3_tprod_ff) : (s3_diff_ff > s3_thr_ff);
      refresh = s3_first_ff || moved || (s3_cnt_ff == '0);

      // truncate to Q16.16 and saturate; a zero here is the denormal flush
      dshift = s3_dprod_ff[DPROD_W-1:SBT_DAMP_SHIFT];
      damped = (dshift[DSH_W-1:SBT_AMP_W] != '0) ? '1 : dshift[SBT_AMP_W-1:0];

      if (refresh) begin
         state_wdata.amp  = s3_amp_ff;
         state_wdata.freq = s3_freq_ff;
         state_wdata.cnt  = hold_frames_ff;
      end else begin
         state_wdata.amp  = damped;
         state_wdata.freq = s3_hfreq_ff;
         state_wdata.cnt  = hold_forever_ff ? s3_cnt_ff : s3_cnt_ff - 1'b1;
      end
   end

   assign state_we = adv && s3_valid_ff;

   // ---------------- output register ----------------
   logic [SBT_BIN_W-1:0]  rsp_bin_ff;
   logic [SBT_AMP_W-1:0]  rsp_amp_ff;
   logic [SBT_FREQ_W-1:0] rsp_freq_ff;
   logic                  rsp_refreshed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_bin_ff       <= s3_bin_ff;
         rsp_amp_ff       <= state_wdata.amp;
         rsp_freq_ff      <= state_wdata.freq;
         rsp_refreshed_ff <= refresh;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_bin       = rsp_bin_ff;
   assign rsp.out_amplitude = rsp_amp_ff;
   assign rsp.out_frequency = rsp_freq_ff;
   assign rsp.refreshed     = rsp_refreshed_ff;

endmodule

`default_nettype wire

FILE: dv/tb_spectral_bin_thresher_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for spectral_bin_thresher_top: directed and random bin
// requests, register sweeps and backpressure, scored by a per-bin hold/damp predictor.
// Depends on sbt_pkg, the sbt_*_if channel interfaces and the top level RTL.

module tb_spectral_bin_thresher_top;
   import sbt_pkg::*;

   localparam int TOP_BIN      = SBT_FFT_SIZE_DEF / 2;
   localparam int NBINS        = SBT_NBINS_DEF;
   localparam int MAX_BIN_CODE = (1 << SBT_BIN_W) - 1;
   // Covers the pipeline and the same-bin interlock; room for requests with no result.
   localparam int DRAIN_CYCLES = 12;
   // Watchdog limit; the slowest run (clear pass, ~410 requests with gaps, stalls
   // and interlocks, phase drains) stays far below it.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   // One request as the sender sees it
   typedef struct {
      sbt_action_type               action;
      logic [SBT_BIN_W-1:0]         bin;
      logic [SBT_AMP_W-1:0]         amp;
      logic signed [SBT_FREQ_W-1:0] freq;
      logic [SBT_THR_W-1:0]         thr;
      logic [SBT_DAMP_W-1:0]        damp;
   } bin_req_type;

   // One result as the block returns it
   typedef struct {
      logic [SBT_BIN_W-1:0]         bin;
      logic [SBT_AMP_W-1:0]         amp;
      logic signed [SBT_FREQ_W-1:0] freq;
      logic                         refreshed;
   } bin_rsp_type;

   logic clock;
   logic reset;

   sbt_req_if req_bus ();
   sbt_rsp_if rsp_bus ();
   sbt_csr_if csr_bus ();

   spectral_bin_thresher_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // ---------------------------------------------------------------------------
   // Predictor state: per-bin held values and coefficients, plus register copies
   // ---------------------------------------------------------------------------
   logic [SBT_AMP_W-1:0]   held_amp   [NBINS];
   logic [SBT_FREQ_W-1:0]  held_freq  [NBINS];
   logic [SBT_CNT_W-1:0]   hold_count [NBINS];
   logic [SBT_THR_W-1:0]   bin_thr    [NBINS];
   logic [SBT_DAMP_W-1:0]  bin_damp   [NBINS];
   logic                   copy_all;
   logic [SBT_CNT_W-1:0]   cfg_hold_frames;
   logic                   cfg_hold_inf;
   logic [SBT_SCALE_W-1:0] cfg_thr_scale;
   logic [SBT_SCALE_W-1:0] cfg_damp_scale;

   // Results still owed by the block, oldest first
   bin_rsp_type expected_bins [$];

   // Traffic shaping shared between the test tasks and the response sink
   int burst_left   = 0;
   bit tx_no_gaps   = 1'b0;
   int rx_hold_left = 0;

   // Run statistics
   int cycle_count     = 0;
   int fail_count      = 0;
   int requests_sent   = 0;
   int writes_sent     = 0;
   int ignored_sent    = 0;
   int results_checked = 0;
   int refreshed_seen  = 0;
   int settings_loaded = 0;

   // ---------------------------------------------------------------------------
   // Bin hold/damp predictor
   // ---------------------------------------------------------------------------
   function automatic void clear_bin_model();
      for (int k = 0; k < NBINS; k++) begin
         held_amp[k]   = '0;
         held_freq[k]  = '0;
         hold_count[k] = '0;
         bin_thr[k]    = SBT_THR_RST;
         bin_damp[k]   = SBT_DAMP_RST;
      end
      copy_all        = 1'b1;
      cfg_hold_frames = SBT_HOLD_FRAMES_RST;
      cfg_hold_inf    = 1'b0;
      cfg_thr_scale   = SBT_SCALE_RST;
      cfg_damp_scale  = SBT_SCALE_RST;
   endfunction

   function automatic bit near_one(input logic [SBT_SCALE_W-1:0] s);
      return s >= SBT_WIN_LO && s <= SBT_WIN_HI;
   endfunction

   // Applies one accepted request; returns 1 and the result when one is due.
   function automatic bit predict_bin_update(input bin_req_type r, output bin_rsp_type rsp);
      logic [63:0] diff;
      logic [63:0] gain;
      logic [63:0] product;
      bit          take;
      int          b;
      b   = r.bin;
      rsp = '{default: '0};
      if (r.action == SBT_ACT_WRITE) begin
         // top bin and anything above keep their coefficients
         if (b < TOP_BIN) begin
            bin_thr[b]  = r.thr;
            bin_damp[b] = r.damp;
         end
         return 1'b0;
      end
      if (b > TOP_BIN) return 1'b0;

      take = copy_all || hold_count[b] == '0;
      if (!take) begin
         diff = (held_amp[b] > r.amp) ? 64'(held_amp[b] - r.amp) : 64'(r.amp - held_amp[b]);
         // scaled compare as soon as either scale leaves its near-one window
         if (near_one(cfg_thr_scale) && near_one(cfg_damp_scale))
            take = diff > 64'(bin_thr[b]);
         else
            take = (diff << SBT_SCALE_FRAC) > 64'(bin_thr[b]) * 64'(cfg_thr_scale);
      end
      if (copy_all && b == TOP_BIN) copy_all = 1'b0;

      if (take) begin
         held_amp[b]   = r.amp;
         held_freq[b]  = r.freq;
         hold_count[b] = cfg_hold_frames;
      end else begin
         if (!cfg_hold_inf) hold_count[b] = hold_count[b] - 1'b1;
         gain    = 64'(bin_damp[b]) * 64'(cfg_damp_scale);
         product = (64'(held_amp[b]) * gain) >> SBT_DAMP_SHIFT;
         held_amp[b] = (product > 64'hFFFF_FFFF) ? '1 : product[SBT_AMP_W-1:0];
      end
      rsp.bin       = r.bin;
      rsp.amp       = held_amp[b];
      rsp.freq      = held_freq[b];
      rsp.refreshed = take;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------------------
   function automatic bin_req_type make_process(input int bin, input logic [31:0] amp,
                                                input logic [31:0] freq);
      bin_req_type r;
      r.action = SBT_ACT_PROCESS;
      r.bin    = SBT_BIN_W'(bin);
      r.amp    = amp;
      r.freq   = freq;
      r.thr    = $urandom;
      r.damp   = SBT_DAMP_W'($urandom);
      return r;
   endfunction

   function automatic bin_req_type make_bin_write(input int bin, input logic [31:0] thr,
                                                  input logic [15:0] damp);
      bin_req_type r;
      r.action = SBT_ACT_WRITE;
      r.bin    = SBT_BIN_W'(bin);
      r.amp    = $urandom;
      r.freq   = $urandom;
      r.thr    = thr;
      r.damp   = damp;
      return r;
   endfunction

   // Most traffic lands on a few low and top bins so their state gets revisited.
   function automatic int focus_bin();
      int b;
      b = $urandom_range(0, 15);
      return (b < 8) ? b : TOP_BIN - 15 + b;
   endfunction

   function automatic bin_req_type random_bin_request();
      bin_req_type r;
      int unsigned pick;
      logic [31:0] delta;
      logic [31:0] base;
      pick = $urandom_range(0, 99);
      r    = make_process(($urandom_range(0, 4) == 0) ? $urandom_range(0, TOP_BIN) : focus_bin(),
                          $urandom, $urandom);
      if (pick < 8) begin
         // coefficient write, sometimes to the top bin or beyond
         r.action = SBT_ACT_WRITE;
         if ($urandom_range(0, 4) == 0) r.bin = SBT_BIN_W'($urandom_range(0, MAX_BIN_CODE));
         case ($urandom_range(0, 2))
            0: r.thr = $urandom_range(0, 1 << 17);
            1: r.thr = '0;
            default: ;
         endcase
      end else if (pick < 13) begin
         r.bin = SBT_BIN_W'($urandom_range(TOP_BIN + 1, MAX_BIN_CODE));
      end else if (pick < 75) begin
         // amplitude close to the held one, so the threshold decides
         base = held_amp[r.bin];
         case ($urandom_range(0, 3))
            0: delta = '0;
            1: delta = $urandom_range(0, 8191);
            2: delta = $urandom_range(0, 16'hFFFF);
            default: delta = $urandom_range(0, 1 << 20);
         endcase
         if ($urandom_range(0, 1) == 1)
            r.amp = (base > 32'hFFFF_FFFF - delta) ? '1 : base + delta;
         else
            r.amp = (delta > base) ? '0 : base - delta;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: bursts with random gaps; valid stays up between
   // back-to-back requests of a burst.
   // ---------------------------------------------------------------------------
   task automatic send_bin_request(input bin_req_type r, output bit gives_result);
      int unsigned gap;
      bin_rsp_type rsp;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         if (gap != 0 && !tx_no_gaps) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.action        <= r.action;
      req_bus.bin_index     <= r.bin;
      req_bus.amplitude     <= r.amp;
      req_bus.frequency     <= r.freq;
      req_bus.new_threshold <= r.thr;
      req_bus.new_damping   <= r.damp;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      // accepted at this edge: predict now, in acceptance order
      requests_sent++;
      gives_result = predict_bin_update(r, rsp);
      if (gives_result) expected_bins.push_back(rsp);
      else if (r.action == SBT_ACT_WRITE) writes_sent++;
      else ignored_sent++;
   endtask

   // Drop valid, let every owed result arrive, then let the pipeline empty.
   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      while (expected_bins.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers back to back; only called with the block idle.
   task automatic load_settings(input logic [SBT_CNT_W-1:0] frames, input logic hold_inf,
                                input logic [SBT_SCALE_W-1:0] thr_scale,
                                input logic [SBT_SCALE_W-1:0] damp_scale);
      sbt_reg_type               idx;
      logic [SBT_CSR_DATA_W-1:0] value;
      for (int k = 0; k < 4; k++) begin
         idx = sbt_reg_type'(k);
         case (idx)
            SBT_REG_HOLD_FRAMES: begin
               value = frames;
               cfg_hold_frames = frames;
            end
            SBT_REG_HOLD_FOREVER: begin
               value = SBT_CSR_DATA_W'(hold_inf);
               cfg_hold_inf = hold_inf;
            end
            SBT_REG_THR_SCALE: begin
               value = thr_scale;
               cfg_thr_scale = thr_scale;
            end
            default: begin
               value = damp_scale;
               cfg_damp_scale = damp_scale;
            end
         endcase
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx;
         csr_bus.data  <= value;
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
      end
      csr_bus.valid <= 1'b0;
      settings_loaded++;
   endtask

   // Sends random requests until `count` of them have produced a result.
   task automatic run_random_requests(input int count);
      int made;
      bit gives;
      made = 0;
      while (made < count) begin
         send_bin_request(random_bin_request(), gives);
         if (gives) made++;
      end
   endtask

   task automatic run_phase(input logic [SBT_CNT_W-1:0] frames, input logic hold_inf,
                            input logic [SBT_SCALE_W-1:0] thr_scale,
                            input logic [SBT_SCALE_W-1:0] damp_scale, input int count);
      wait_for_idle();
      load_settings(frames, hold_inf, thr_scale, damp_scale);
      run_random_requests(count);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // First frame: every bin copies its input; out-of-range bins and writes
   // to the top bin are dropped; the top bin ends the first frame.
   task automatic test_opening_frame();
      bit gives;
      send_bin_request(make_process(0, 32'h0000_0000, 32'h8000_0000), gives);
      send_bin_request(make_process(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF), gives);
      send_bin_request(make_process(TOP_BIN - 1, 32'hFFFF_FFFF, 32'h0000_0000), gives);
      send_bin_request(make_process(TOP_BIN + 1, 32'h1234_5678, 32'h0BAD_F00D), gives);
      send_bin_request(make_process(MAX_BIN_CODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF), gives);
      send_bin_request(make_bin_write(TOP_BIN, 32'h0, 16'h0), gives);
      send_bin_request(make_bin_write(TOP_BIN - 1, 32'hFFFF_FFFF, 16'hFFFF), gives);
      send_bin_request(make_bin_write(0, 32'h0, 16'h0), gives);
      send_bin_request(make_bin_write(MAX_BIN_CODE, 32'h0, 16'h0), gives);
      send_bin_request(make_process(TOP_BIN, 32'h0001_0000, 32'h0064_0000), gives);
   endtask

   // Steady state: hold with damping, flush to zero, saturation, the exact
   // threshold edge and the forced refresh of a bin whose countdown is zero.
   task automatic test_hold_and_damp();
      bit gives;
      send_bin_request(make_process(0, 32'h0000_0000, 32'h1234_0000), gives);
      send_bin_request(make_process(1, 32'hFFFF_FFFF, 32'h7FFF_0000), gives);
      // difference equal to the threshold holds, one more refreshes
      send_bin_request(make_process(1, held_amp[1] + bin_thr[1], 32'h0000_1000), gives);
      send_bin_request(make_process(1, held_amp[1] + bin_thr[1] + 1, 32'hFFFF_0000), gives);
      // full threshold and damping: held full-scale amplitude saturates
      send_bin_request(make_process(TOP_BIN - 1, 32'h0000_0000, 32'h5555_5555), gives);
      send_bin_request(make_process(TOP_BIN, 32'h0001_0000, 32'hAAAA_AAAA), gives);
      send_bin_request(make_process(7, 32'h0ABC_0000, 32'hC000_0000), gives);
      send_bin_request(make_process(TOP_BIN + 1, 32'h0, 32'h0), gives);
      send_bin_request(make_process(MAX_BIN_CODE, 32'h0, 32'h0), gives);
      send_bin_request(make_bin_write(TOP_BIN, 32'h0, 16'h0), gives);
   endtask

   // Register extremes: short, zero and infinite hold, zero and full-scale
   // scales, and both edges of the near-one window from inside and outside.
   task automatic test_settings_sweep();
      run_phase(16'd3,     1'b0, SBT_SCALE_RST, SBT_SCALE_RST, 20);
      run_phase(16'd0,     1'b0, SBT_SCALE_RST, SBT_SCALE_RST, 20);
      run_phase(16'hFFFF,  1'b1, SBT_SCALE_RST, SBT_SCALE_RST, 20);
      run_phase(16'd2,     1'b0, 16'd0,         SBT_SCALE_RST, 20);
      run_phase(16'd5,     1'b0, 16'hFFFF,      16'hFFFF,      20);
      run_phase(16'd4,     1'b0, SBT_WIN_LO,    SBT_WIN_HI,    20);
      run_phase(16'd4,     1'b0, SBT_WIN_LO - 1'b1, SBT_SCALE_RST, 20);
      run_phase(16'd4,     1'b1, SBT_SCALE_RST, SBT_WIN_HI + 1'b1, 20);
      run_phase(16'd6,     1'b0, SBT_SCALE_RST, 16'd0,         20);
   endtask

   // Random register settings, half of the scales inside the window.
   task automatic test_random_traffic();
      logic [SBT_SCALE_W-1:0] ts;
      logic [SBT_SCALE_W-1:0] ds;
      repeat (3) begin
         ts = ($urandom_range(0, 1) == 1) ?
              SBT_SCALE_W'($urandom_range(SBT_WIN_LO, SBT_WIN_HI)) : SBT_SCALE_W'($urandom);
         ds = ($urandom_range(0, 1) == 1) ?
              SBT_SCALE_W'($urandom_range(SBT_WIN_LO, SBT_WIN_HI)) : SBT_SCALE_W'($urandom);
         tx_no_gaps = ($urandom_range(0, 2) == 0);
         run_phase(SBT_CNT_W'($urandom_range(0, 12)), 1'($urandom_range(0, 1)), ts, ds, 40);
      end
      tx_no_gaps = 1'b0;
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so the
   // block fills and stalls its input; then the sender waits for a full drain.
   task automatic test_backpressure();
      bit gives;
      wait_for_idle();
      load_settings(16'd4, 1'b0, SBT_SCALE_RST, SBT_SCALE_RST);
      tx_no_gaps   = 1'b1;
      rx_hold_left = 200;
      for (int k = 0; k < 32; k++)
         send_bin_request(make_process(k, $urandom, $urandom), gives);
      tx_no_gaps = 1'b0;
      wait_for_idle();
      run_random_requests(12);
   endtask

   // ---------------------------------------------------------------------------
   // Clock, reset and test sequence
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      clear_bin_model();
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.action        <= SBT_ACT_PROCESS;
      req_bus.bin_index     <= '0;
      req_bus.amplitude     <= '0;
      req_bus.frequency     <= '0;
      req_bus.new_threshold <= '0;
      req_bus.new_damping   <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= SBT_REG_HOLD_FRAMES;
      csr_bus.data          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // the block clears its bin memories first; the driver simply waits on ready
      test_opening_frame();
      test_hold_and_damp();
      test_settings_sweep();
      test_random_traffic();
      test_backpressure();

      wait_for_idle();
      $display("covered %0d requests (%0d coefficient writes, %0d out-of-range), %0d results",
               requests_sent, writes_sent, ignored_sent, results_checked);
      $display("%0d refreshed, %0d held; %0d register settings; %0d mismatches",
               refreshed_seen, results_checked - refreshed_seen, settings_loaded, fail_count);
      if (fail_count == 0 && expected_bins.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: ends a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_bins.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Response sink: long hold-off when asked, otherwise a stall mode picked at random
   // for each stretch (always ready, coin toss, 1-in-4, rare stall).
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned phase;
      mode      = 0;
      mode_left = 0;
      phase     = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            phase++;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_bus.ready <= (phase % 4 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result checker: in-order compare against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      bin_rsp_type want;
      bin_rsp_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.bin       = rsp_bus.out_bin;
         got.amp       = rsp_bus.out_amplitude;
         got.freq      = rsp_bus.out_frequency;
         got.refreshed = rsp_bus.refreshed;
         if (expected_bins.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("%0t: unexpected result bin %0d amp %h freq %h refreshed %b",
                        $realtime, got.bin, got.amp, got.freq, got.refreshed);
         end else begin
            want = expected_bins.pop_front();
            results_checked++;
            if (got.refreshed === 1'b1) refreshed_seen++;
            if (got.bin !== want.bin || got.amp !== want.amp ||
                got.freq !== want.freq || got.refreshed !== want.refreshed) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display({"%0t: result mismatch, expected bin %0d amp %h freq %h ref %b,",
                            " got bin %0d amp %h freq %h ref %b"}, $realtime,
                           want.bin, want.amp, want.freq, want.refreshed,
                           got.bin, got.amp, got.freq, got.refreshed);
            end
         end
      end
   end

endmodule
